// File: hdl/command_line_tokenizer_macros.svh
// Assertion macros used by the checker file of the tokenizer.
`ifndef COMMAND_LINE_TOKENIZER_MACROS_SVH
`define COMMAND_LINE_TOKENIZER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define CLT_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define CLT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/clt_pkg.sv
`default_nettype none

package clt_pkg;

	// Default limit on tokens per line.
	localparam int MAX_TOKENS_DEF = 32;

	// Depth of the result queue; it must take two results while holding two.
	localparam int QUEUE_DEPTH = 4;

	// Result kinds.
	localparam logic [1:0] KIND_CHAR  = 2'd0;
	localparam logic [1:0] KIND_END   = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	// Quote modes.
	localparam logic [1:0] QM_NONE   = 2'd0;
	localparam logic [1:0] QM_SINGLE = 2'd1;
	localparam logic [1:0] QM_DOUBLE = 2'd2;

	// Marker bytes written into the token stream.
	localparam logic [7:0] QUOTE_MARK  = 8'h1F;
	localparam logic [7:0] DOLLAR_MARK = 8'h01;

	// Bytes the tokenizer reacts to.
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] CH_SQUOTE  = 8'h27;
	localparam logic [7:0] CH_DQUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH  = 8'h5C;
	localparam logic [7:0] CH_DOLLAR  = 8'h24;

	// One input word: a byte of the command line.
	typedef struct packed {
		logic [7:0] char_in;
		logic       line_end;
	} item_t;

	// One result word.
	typedef struct packed {
		logic [7:0] char_out;
		logic [1:0] kind;
		logic [4:0] token_index;
		logic       last;
	} result_t;

	// Results produced by one accepted byte, in order.
	typedef struct packed {
		logic [1:0] count;
		result_t    r0;
		result_t    r1;
	} step_res_t;

endpackage

`default_nettype wire

// File: hdl/clt_core.sv
`default_nettype none

module clt_core import clt_pkg::*; #(
	parameter int MAX_TOKENS = MAX_TOKENS_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      fire,
	input  wire item_t     item,
	output step_res_t      res
);

	localparam int CW = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1;
	localparam int EW = (CW > 5) ? CW : 5;
	localparam logic [CW-1:0] CNT_LAST = CW'(MAX_TOKENS - 1);

	logic [1:0]    quote_q;
	logic          esc_q;
	logic          skip_q;
	logic [CW-1:0] cnt_q;
	logic          err_q;

	logic [1:0]    quote_d;
	logic          esc_d;
	logic          skip_d;
	logic [CW-1:0] cnt_d;
	logic          err_d;
	step_res_t     res_d;

	// Next state and results for the byte on the input.
	always_comb begin
		logic [7:0]    c;
		logic          is_ws;
		logic          has_p;
		logic          has_s;
		logic          raised;
		result_t       p;
		result_t       s;
		logic [EW-1:0] idx_now;
		logic [EW-1:0] idx_next;

		c        = item.char_in;
		is_ws    = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
		quote_d  = quote_q;
		esc_d    = esc_q;
		skip_d   = skip_q;
		cnt_d    = cnt_q;
		err_d    = err_q;
		has_p    = 1'b0;
		has_s    = 1'b0;
		raised   = 1'b0;
		idx_now  = EW'(cnt_q);
		p        = '{char_out: 8'h00, kind: KIND_CHAR, token_index: idx_now[4:0],
			last: 1'b0};
		s        = '{char_out: 8'h00, kind: KIND_END, token_index: idx_now[4:0],
			last: 1'b1};

		if (!err_q) begin
			priority if (esc_q) begin
				esc_d      = 1'b0;
				skip_d     = 1'b0;
				has_p      = 1'b1;
				p.char_out = (c == CH_DOLLAR) ? DOLLAR_MARK : c;
			end else if (((quote_q == QM_SINGLE) && (c == CH_SQUOTE)) ||
				((quote_q == QM_DOUBLE) && (c == CH_DQUOTE))) begin
				quote_d    = QM_NONE;
				has_p      = 1'b1;
				p.char_out = QUOTE_MARK;
			end else if (is_ws && (quote_q == QM_NONE)) begin
				// Unquoted whitespace closes the token once.
				if (!skip_q) begin
					has_p  = 1'b1;
					p.kind = KIND_END;
					cnt_d  = cnt_q + 1'b1;
					if (cnt_q == CNT_LAST) begin
						raised = 1'b1;
						err_d  = 1'b1;
					end else begin
						skip_d = 1'b1;
					end
				end
			end else if ((c == CH_BSLASH) && !item.line_end) begin
				esc_d  = 1'b1;
				skip_d = 1'b0;
			end else if ((c == CH_SQUOTE) && (quote_q == QM_NONE)) begin
				quote_d    = QM_SINGLE;
				skip_d     = 1'b0;
				has_p      = 1'b1;
				p.char_out = QUOTE_MARK;
			end else if ((c == CH_DQUOTE) && (quote_q == QM_NONE)) begin
				quote_d    = QM_DOUBLE;
				skip_d     = 1'b0;
				has_p      = 1'b1;
				p.char_out = QUOTE_MARK;
			end else begin
				skip_d     = 1'b0;
				has_p      = 1'b1;
				p.char_out = c;
			end

			// The error follows the token end; otherwise the line end closes
			// the current token.
			idx_next = EW'(cnt_d);
			if (raised) begin
				has_s  = 1'b1;
				s.kind = KIND_ERROR;
			end else if (item.line_end) begin
				has_s         = 1'b1;
				s.token_index = idx_next[4:0];
			end
		end else begin
			idx_next = idx_now;
		end

		// A line end always returns the state to reset.
		if (item.line_end) begin
			quote_d = QM_NONE;
			esc_d   = 1'b0;
			skip_d  = 1'b0;
			cnt_d   = '0;
			err_d   = 1'b0;
		end

		// Pack the results in order.
		if (has_p) begin
			res_d.r0    = p;
			res_d.r1    = s;
			res_d.count = {has_s, ~has_s};
		end else begin
			res_d.r0    = s;
			res_d.r1    = s;
			res_d.count = {1'b0, has_s};
		end
	end

	// Results go to the queue only for an accepted word.
	always_comb begin
		res       = res_d;
		res.count = fire ? res_d.count : 2'd0;
	end

	// Tokenizer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quote_q <= QM_NONE;
			esc_q   <= 1'b0;
			skip_q  <= 1'b0;
			cnt_q   <= '0;
			err_q   <= 1'b0;
		end else if (fire) begin
			quote_q <= quote_d;
			esc_q   <= esc_d;
			skip_q  <= skip_d;
			cnt_q   <= cnt_d;
			err_q   <= err_d;
		end
	end

endmodule

`default_nettype wire

// File: hdl/clt_queue.sv
`default_nettype none

module clt_queue import clt_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire step_res_t push,
	input  wire logic      pop,
	output result_t        head,
	output logic           not_empty,
	output logic           room
);

	localparam int PW = $clog2(QUEUE_DEPTH);

	result_t       mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wp_q;
	logic [PW-1:0] rp_q;
	logic [PW:0]   fill_q;

	// Room for two more results, the most one word can produce.
	assign room      = (fill_q <= (PW+1)'(QUEUE_DEPTH - 2));
	assign not_empty = (fill_q != '0);
	assign head      = mem_q[rp_q];

	// Result storage.
	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wp_q] <= push.r0;
		end
		if (push.count == 2'd2) begin
			mem_q[PW'(wp_q + 1'b1)] <= push.r1;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			rp_q   <= '0;
			fill_q <= '0;
		end else begin
			wp_q   <= PW'(wp_q + PW'(push.count));
			rp_q   <= PW'(rp_q + PW'(pop));
			fill_q <= fill_q + (PW+1)'(push.count) - (PW+1)'(pop);
		end
	end

endmodule

`default_nettype wire

// File: hdl/command_line_tokenizer.sv
// Results: each result word is written into the result queue and offered from its head.
// Throughput: one byte per cycle while each byte gives at most one result and the
// output is not stalled; a byte that gives two results (any result followed by the
// line-end token end, or a token end plus the error) sends them out one at a time,
// through the single read port of the four-entry result queue.
// Reset: arst_n clears the tokenizer state and empties the result queue.
`default_nettype none

module command_line_tokenizer import clt_pkg::*; #(
	parameter int MAX_TOKENS = MAX_TOKENS_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    item_valid,
	output logic         item_ready,
	input  wire item_t   item,
	output logic         result_valid,
	input  wire logic    result_ready,
	output result_t      result
);

	logic      fire;
	logic      room;
	step_res_t res;

	// A byte is taken whenever the queue can hold both possible results.
	assign item_ready = room;
	assign fire       = item_valid && room;

	// Per-byte tokenizer logic and state.
	clt_core #(
		.MAX_TOKENS(MAX_TOKENS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item),
		.res    (res)
	);

	// Result queue decouples the output side.
	clt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res),
		.pop       (result_valid && result_ready),
		.head      (result),
		.not_empty (result_valid),
		.room      (room)
	);

endmodule

`default_nettype wire

// File: hdl/clt_checker.sv
`default_nettype none
`include "command_line_tokenizer_macros.svh"

module clt_checker import clt_pkg::*; (
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    item_valid,
	input wire logic    item_ready,
	input wire item_t   item,
	input wire logic    result_valid,
	input wire logic    result_ready,
	input wire result_t result
);

	// A stalled input word stays offered with the same payload.
	`CLT_ASSERT_NEXT(a_item_hold, item_valid && !item_ready, item_valid && $stable(item), "input word changed while stalled")

	// A stalled result word stays offered.
	`CLT_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid, "result dropped while stalled")

	// The final word of a line is a token end or the error, never a character.
	`CLT_ASSERT_IMP(a_last_kind, result_valid && result.last, result.kind != KIND_CHAR, "last set on a character")

	// The error closes the line and carries no byte.
	`CLT_ASSERT_IMP(a_error_last, result_valid && (result.kind == KIND_ERROR), result.last && (result.char_out == 8'h00), "error word malformed")

	// Token ends carry no byte either.
	`CLT_ASSERT_IMP(a_end_zero, result_valid && (result.kind == KIND_END), result.char_out == 8'h00, "token end carries a byte")

endmodule

bind command_line_tokenizer clt_checker u_clt_checker (.*);

`default_nettype wire
